FILE: rtl/spoken_word_segmenter_defines.svh
// Assertion macros shared by the spoken word segmenter RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef SPOKEN_WORD_SEGMENTER_DEFINES_SVH
`define SPOKEN_WORD_SEGMENTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("segmenter check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("segmenter check failed");

`endif

FILE: rtl/sws_pkg.sv
// Shared types and constants of the spoken word segmenter.
// Depends on nothing; every other RTL file but the defines header imports it.
package sws_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int MAG_BITS      = 15;
  localparam int POS_BITS      = 24;
  localparam int WORD_IDX_BITS = 4;
  localparam int MAX_WORDS     = 12;
  localparam int CFG_ADDR_BITS = 5;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [MAG_BITS-1:0] NOISE_FLOOR = MAG_BITS'(10);
  localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_ONSET_THRESHOLD    = 3'd0,
    REG_CALIBRATION_LENGTH = 3'd1,
    REG_MIN_WORD_LENGTH    = 3'd2,
    REG_MIN_DISCARD_LENGTH = 3'd3,
    REG_SILENCE_LIMIT      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [14:0] onset_threshold;
    logic [23:0] calibration_length;
    logic [15:0] min_word_length;
    logic [15:0] min_discard_length;
    logic [7:0]  silence_limit;
  } cfg_t;

  typedef struct packed {
    logic [23:0]              word_start;
    logic [23:0]              word_end;
    logic [WORD_IDX_BITS-1:0] word_index;
  } result_t;

endpackage

FILE: rtl/sws_if.sv
// Stream interfaces of the spoken word segmenter: sample beats in, word beats out.
// Depends on sws_pkg for field widths.
interface sws_in_if;
  import sws_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;
  logic                          restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink (input valid, input sample, input restart, output ready);
endinterface

interface sws_out_if;
  import sws_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [23:0]              word_start;
  logic [23:0]              word_end;
  logic [WORD_IDX_BITS-1:0] word_index;

  modport source (output valid, output word_start, output word_end, output word_index,
                  input ready);
  modport sink (input valid, input word_start, input word_end, input word_index,
                output ready);
endinterface

FILE: rtl/spoken_word_segmenter.sv
// Top level of the spoken word segmenter: register port, input stage, output queue.
// Depends on sws_pkg, sws_if.sv, sws_core and spoken_word_segmenter_defines.svh.
//
//   channel   direction  beat contents
//   in_ch     in         sample (signed 16), restart (1)
//   out_ch    out        word_start (24), word_end (24), word_index (4)
//   APB port  in/out     five configuration registers at byte address 4*index
//
// One sample beat is taken per cycle while the skid entry is free; each goes from
// acceptance into the input register, then through the segmentation update into the
// output register. The rate is set by that single update step.
// Reset clears the registers to their defaults and the stream state; restart on a
// sample clears the stream state only. A stalled output holds one result and one
// more in a skid entry; input stops only when the skid entry is occupied.
`include "spoken_word_segmenter_defines.svh"

module spoken_word_segmenter (
  input  logic                                 clk,
  input  logic                                 rst_n,
  sws_in_if.sink                               in_ch,
  sws_out_if.source                            out_ch,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sws_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [sws_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [sws_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import sws_pkg::*;

  // Configuration registers. Writes land in the access phase; pready never stalls.
  cfg_t     cfg_r;
  reg_idx_t reg_sel;
  logic     wr_en;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_BITS-1:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.onset_threshold    <= 15'd400;
      cfg_r.calibration_length <= 24'd48000;
      cfg_r.min_word_length    <= 16'd9000;
      cfg_r.min_discard_length <= 16'd2000;
      cfg_r.silence_limit      <= 8'd30;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_ONSET_THRESHOLD:    cfg_r.onset_threshold    <= pwdata[14:0];
        REG_CALIBRATION_LENGTH: cfg_r.calibration_length <= pwdata[23:0];
        REG_MIN_WORD_LENGTH:    cfg_r.min_word_length    <= pwdata[15:0];
        REG_MIN_DISCARD_LENGTH: cfg_r.min_discard_length <= pwdata[15:0];
        REG_SILENCE_LIMIT:      cfg_r.silence_limit      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Reads return the register zero-extended; addresses past the list read zero.
  always_comb begin
    unique case (reg_sel)
      REG_ONSET_THRESHOLD:    prdata = CFG_DATA_BITS'(cfg_r.onset_threshold);
      REG_CALIBRATION_LENGTH: prdata = CFG_DATA_BITS'(cfg_r.calibration_length);
      REG_MIN_WORD_LENGTH:    prdata = CFG_DATA_BITS'(cfg_r.min_word_length);
      REG_MIN_DISCARD_LENGTH: prdata = CFG_DATA_BITS'(cfg_r.min_discard_length);
      REG_SILENCE_LIMIT:      prdata = CFG_DATA_BITS'(cfg_r.silence_limit);
      default:                prdata = '0;
    endcase
  end

  // Input register. The held sample is processed whenever the output queue can
  // absorb a possible result, which is whenever the skid entry is free.
  logic                          in_valid_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic                          restart_r;
  logic                          skid_valid_r;
  logic                          proc;

  assign proc        = in_valid_r && !skid_valid_r;
  assign in_ch.ready = !in_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      sample_r  <= in_ch.sample;
      restart_r <= in_ch.restart;
    end
  end

  // Segmentation state and its update for the held sample.
  logic    emit;
  result_t core_res;

  sws_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc),
    .sample  (sample_r),
    .restart (restart_r),
    .cfg     (cfg_r),
    .emit    (emit),
    .res     (core_res)
  );

  // Output register with one skid entry behind it. The skid entry only fills when
  // a result arrives while the output register is stalled.
  logic    out_valid_r;
  result_t out_r, skid_r;
  logic    pop;

  assign pop = out_valid_r && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (emit) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_r <= skid_r;
      end
    end else if (emit) begin
      if (out_valid_r && !pop) begin
        skid_r <= core_res;
      end else begin
        out_r <= core_res;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_start = out_r.word_start;
  assign out_ch.word_end   = out_r.word_end;
  assign out_ch.word_index = out_r.word_index;

  // The skid entry is never occupied with the output register empty.
  `SWS_ASSERT_NOW(a_skid_behind_out, clk, rst_n, skid_valid_r, out_valid_r)
  // A word is emitted only while the word count is below the limit.
  `SWS_ASSERT_NOW(a_word_limit, clk, rst_n, emit, core_res.word_index < WORD_IDX_BITS'(MAX_WORDS))
  // After the core produces a result, the output holds a valid result the next cycle.
  `SWS_ASSERT_NEXT(a_emit_shown, clk, rst_n, emit, out_valid_r)

endmodule

FILE: rtl/sws_core.sv
// Per-sample segmentation state and its combinational update, registered on each step.
// Depends on sws_pkg.
module sws_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   step,
  input  logic signed [sws_pkg::SAMPLE_BITS-1:0] sample,
  input  logic                                   restart,
  input  sws_pkg::cfg_t                          cfg,
  output logic                                   emit,
  output sws_pkg::result_t                       res
);
  import sws_pkg::*;

  logic [POS_BITS-1:0]      position_r, position_nxt;
  logic [MAG_BITS-1:0]      noise_level_r, noise_level_nxt;
  logic                     in_word_r, in_word_nxt;
  logic [POS_BITS-1:0]      onset_r, onset_nxt;
  logic [MAG_BITS-1:0]      peak_r, peak_nxt;
  logic [7:0]               quiet_r, quiet_nxt;
  logic [SAMPLE_BITS-1:0]   prev_r, prev_nxt;
  logic [POS_BITS-1:0]      run_prev_r, run_prev_nxt;
  logic [WORD_IDX_BITS-1:0] words_r, words_nxt;
  logic                     hit;

  always_comb begin
    logic [POS_BITS-1:0]      e_pos, e_onset, e_run, age;
    logic [MAG_BITS-1:0]      e_noise, e_peak, mag, peak_base;
    logic                     e_in_word, crossing;
    logic [7:0]               e_quiet;
    logic [SAMPLE_BITS-1:0]   e_prev, neg;
    logic [WORD_IDX_BITS-1:0] e_words;

    // A restart sample sees freshly cleared state.
    e_pos     = restart ? '0 : position_r;
    e_noise   = restart ? NOISE_FLOOR : noise_level_r;
    e_in_word = restart ? 1'b0 : in_word_r;
    e_onset   = restart ? '0 : onset_r;
    e_peak    = restart ? '0 : peak_r;
    e_quiet   = restart ? '0 : quiet_r;
    e_prev    = restart ? '0 : prev_r;
    e_run     = restart ? '0 : run_prev_r;
    e_words   = restart ? '0 : words_r;

    // Magnitude, with the most negative sample pinned to full scale.
    neg = SAMPLE_BITS'(-sample);
    if (!sample[SAMPLE_BITS-1]) begin
      mag = sample[MAG_BITS-1:0];
    end else if (neg[SAMPLE_BITS-1]) begin
      mag = MAG_MAX;
    end else begin
      mag = neg[MAG_BITS-1:0];
    end

    crossing = (e_peak != '0) && !sample[SAMPLE_BITS-1] &&
               (e_prev[SAMPLE_BITS-1] || (e_prev == '0));
    age       = e_pos - e_onset;
    peak_base = e_peak;
    hit       = 1'b0;

    noise_level_nxt = e_noise;
    in_word_nxt     = e_in_word;
    onset_nxt       = e_onset;
    peak_nxt        = e_peak;
    quiet_nxt       = e_quiet;
    words_nxt       = e_words;

    if (e_pos < cfg.calibration_length) begin
      if (mag > e_noise) begin
        noise_level_nxt = mag;
      end
    end else if (e_pos > cfg.calibration_length) begin
      if (e_in_word) begin
        if (crossing) begin
          if (e_peak > e_noise) begin
            quiet_nxt = '0;
          end else if (age > POS_BITS'(cfg.min_word_length) ||
                       age > POS_BITS'(cfg.min_discard_length)) begin
            if (e_quiet >= cfg.silence_limit) begin
              in_word_nxt = 1'b0;
              quiet_nxt   = '0;
              if (age > POS_BITS'(cfg.min_word_length) &&
                  e_words < WORD_IDX_BITS'(MAX_WORDS)) begin
                hit       = 1'b1;
                words_nxt = e_words + 1'b1;
              end
            end else begin
              quiet_nxt = e_quiet + 1'b1;
            end
          end
          peak_base = '0;
        end
        peak_nxt = (mag > peak_base) ? mag : peak_base;
      end else if (mag > cfg.onset_threshold) begin
        in_word_nxt = 1'b1;
        onset_nxt   = e_run;
        peak_nxt    = '0;
      end
    end

    // Track where the current sign run began.
    if ((e_pos == '0) || (sample[SAMPLE_BITS-1] != e_prev[SAMPLE_BITS-1])) begin
      run_prev_nxt = e_pos;
    end else begin
      run_prev_nxt = e_run;
    end
    prev_nxt     = sample;
    position_nxt = (e_pos == POS_MAX) ? e_pos : e_pos + 1'b1;

    res.word_start = e_onset[23:0];
    res.word_end   = e_pos[23:0];
    res.word_index = e_words;
  end

  assign emit = step && hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r    <= '0;
      noise_level_r <= NOISE_FLOOR;
      in_word_r     <= 1'b0;
      onset_r       <= '0;
      peak_r        <= '0;
      quiet_r       <= '0;
      prev_r        <= '0;
      run_prev_r    <= '0;
      words_r       <= '0;
    end else if (step) begin
      position_r    <= position_nxt;
      noise_level_r <= noise_level_nxt;
      in_word_r     <= in_word_nxt;
      onset_r       <= onset_nxt;
      peak_r        <= peak_nxt;
      quiet_r       <= quiet_nxt;
      prev_r        <= prev_nxt;
      run_prev_r    <= run_prev_nxt;
      words_r       <= words_nxt;
    end
  end

endmodule

FILE: dv/spoken_word_segmenter_test.sv
// Self-checking testbench for spoken_word_segmenter: drives sample beats and APB writes,
// predicts every word beat in-line and compares it against the result channel.
// Depends on sws_pkg and the sws_in_if / sws_out_if interfaces from the RTL.
module spoken_word_segmenter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sws_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  // Settling time for the input register, the output register and the skid entry.
  localparam int SETTLE_CYCLES  = 8;
  // Stretch without any beat or register access after which the run stops as failed.
  localparam int WATCHDOG_LIMIT = 2000;
  // An address past the end of the register map; writes there must be ignored.
  localparam int SPARE_REG_IDX  = 5;
  // Quiet samples stay at or below the noise floor, so they never count as loud.
  localparam int QUIET_MAG      = 10;
  localparam int MAG_LIMIT      = 32767;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  sws_in_if  in_ch ();
  sws_out_if out_ch ();

  logic                     psel = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] paddr = '0;
  logic [CFG_DATA_BITS-1:0] pwdata = '0;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  logic sink_ready = 1'b0;
  assign out_ch.ready = sink_ready;

  spoken_word_segmenter uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------------
  // Shadow copy of the segmenter: register values and stream state at block widths.
  // ---------------------------------------------------------------------------------
  cfg_t                   seg_cfg;
  logic [POS_BITS-1:0]    seg_position;
  logic [MAG_BITS-1:0]    seg_noise;
  logic                   seg_in_word;
  logic [POS_BITS-1:0]    seg_onset;
  logic [MAG_BITS-1:0]    seg_cycle_peak;
  logic [7:0]             seg_quiet;
  logic signed [15:0]     seg_prev_sample;
  logic [POS_BITS-1:0]    seg_run_start;
  logic [WORD_IDX_BITS-1:0] seg_words;

  // Word beats predicted but not yet seen on the result channel, oldest first.
  result_t pending_words[$];

  int  failures = 0;
  int  beats_sent = 0;
  bit  idling_on = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;

  function automatic void clear_stream();
    seg_position    = '0;
    seg_noise       = NOISE_FLOOR;
    seg_in_word     = 1'b0;
    seg_onset       = '0;
    seg_cycle_peak  = '0;
    seg_quiet       = '0;
    seg_prev_sample = '0;
    seg_run_start   = '0;
    seg_words       = '0;
  endfunction

  // Register defaults after reset; restart leaves these alone.
  function automatic void reset_shadow();
    seg_cfg.onset_threshold    = 15'd400;
    seg_cfg.calibration_length = 24'd48000;
    seg_cfg.min_word_length    = 16'd9000;
    seg_cfg.min_discard_length = 16'd2000;
    seg_cfg.silence_limit      = 8'd30;
    clear_stream();
  endfunction

  function automatic void store_register(input int idx, input logic [31:0] value);
    case (idx)
      REG_ONSET_THRESHOLD:    seg_cfg.onset_threshold    = value[14:0];
      REG_CALIBRATION_LENGTH: seg_cfg.calibration_length = value[23:0];
      REG_MIN_WORD_LENGTH:    seg_cfg.min_word_length    = value[15:0];
      REG_MIN_DISCARD_LENGTH: seg_cfg.min_discard_length = value[15:0];
      REG_SILENCE_LIMIT:      seg_cfg.silence_limit      = value[7:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] register_value(input int idx);
    case (idx)
      REG_ONSET_THRESHOLD:    return 32'(seg_cfg.onset_threshold);
      REG_CALIBRATION_LENGTH: return 32'(seg_cfg.calibration_length);
      REG_MIN_WORD_LENGTH:    return 32'(seg_cfg.min_word_length);
      REG_MIN_DISCARD_LENGTH: return 32'(seg_cfg.min_discard_length);
      REG_SILENCE_LIMIT:      return 32'(seg_cfg.silence_limit);
      default:                return '0;
    endcase
  endfunction

  // Advances the shadow by one sample and tells whether it closes a reported word.
  function automatic bit segment_sample(input logic signed [15:0] s, input logic restart,
                                        output result_t word);
    int                  mag;
    int                  age;
    bit                  emitted;
    logic [POS_BITS-1:0] pos;
    emitted = 1'b0;
    word = '0;
    if (restart) clear_stream();
    pos = seg_position;
    // The magnitude of the most negative sample does not fit, so it is clipped.
    mag = (s < 0) ? -int'(s) : int'(s);
    if (mag > MAG_LIMIT) mag = MAG_LIMIT;

    if (pos < seg_cfg.calibration_length) begin
      if (mag > seg_noise) seg_noise = MAG_BITS'(mag);
    end else if (pos > seg_cfg.calibration_length) begin
      // The sample exactly at the calibration length falls through both branches.
      if (seg_in_word) begin
        // A rising zero crossing closes a half-cycle, but only once a peak was seen.
        if (seg_cycle_peak != 0 && s >= 0 && seg_prev_sample <= 0) begin
          age = int'(pos - seg_onset);
          if (seg_cycle_peak > seg_noise) begin
            seg_quiet = '0;
          end else if (age > seg_cfg.min_word_length || age > seg_cfg.min_discard_length) begin
            if (seg_quiet >= seg_cfg.silence_limit) begin
              seg_in_word = 1'b0;
              seg_quiet = '0;
              // Short bursts close silently, and so do words past the word limit.
              if (age > seg_cfg.min_word_length && seg_words < MAX_WORDS) begin
                word.word_start = seg_onset;
                word.word_end   = pos;
                word.word_index = seg_words;
                seg_words++;
                emitted = 1'b1;
              end
            end else begin
              seg_quiet++;
            end
          end
          seg_cycle_peak = '0;
        end
        if (mag > seg_cycle_peak) seg_cycle_peak = MAG_BITS'(mag);
      end else if (mag > seg_cfg.onset_threshold) begin
        // The word reaches back to the start of the sign run of the previous sample.
        seg_in_word = 1'b1;
        seg_onset = seg_run_start;
        seg_cycle_peak = '0;
      end
    end

    if (pos == 0 || ((s < 0) != (seg_prev_sample < 0))) seg_run_start = pos;
    seg_prev_sample = s;
    if (seg_position != POS_MAX) seg_position++;
    return emitted;
  endfunction

  // ---------------------------------------------------------------------------------
  // Result side: random stall bursts on ready, and a checker for each word beat.
  // ---------------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!idling_on) begin
      stall_left <= 0;
      sink_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      // Start a stall burst; stall_left holds the stalled cycles that follow this one.
      stall_left <= $urandom_range(0, 9);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : word_checker
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word beat: start %0d end %0d index %0d",
               out_ch.word_start, out_ch.word_end, out_ch.word_index);
        failures++;
      end else begin
        want = pending_words.pop_front();
        if (out_ch.word_start !== want.word_start) begin
          $error("word_start: expected %0d, got %0d", want.word_start, out_ch.word_start);
          failures++;
        end
        if (out_ch.word_end !== want.word_end) begin
          $error("word_end: expected %0d, got %0d", want.word_end, out_ch.word_end);
          failures++;
        end
        if (out_ch.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, out_ch.word_index);
          failures++;
        end
      end
    end
  end

  // The watchdog restarts on any sample beat, word beat or register access.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || (psel && penable))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------
  // Drivers. Every task starts and ends right after a rising edge.
  // ---------------------------------------------------------------------------------

  // Offers one sample beat, predicts its outcome once accepted, then maybe idles.
  task automatic send_beat(input logic signed [15:0] s, input logic restart);
    result_t word;
    in_ch.valid   <= 1'b1;
    in_ch.sample  <= s;
    in_ch.restart <= restart;
    do @(posedge clk); while (!in_ch.ready);
    if (segment_sample(s, restart, word)) begin
      pending_words.push_back(word);
    end
    beats_sent++;
    if (idling_on && $urandom_range(0, 7) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Holds the sample stream until every predicted word beat has arrived, then lets
  // the pipeline empty of samples that produce nothing.
  task automatic pause_until_drained();
    in_ch.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input int idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    store_register(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic verify_register(input int idx);
    logic [31:0] got;
    reg_idx_t    which;
    which   = reg_idx_t'(idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_BITS'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    if (got !== register_value(idx)) begin
      $error("%s: expected %0h, got %0h", which.name(), register_value(idx), got);
      failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input int onset, input int cal_len, input int min_word,
                                input int min_discard, input int silence);
    pause_until_drained();
    write_register(REG_ONSET_THRESHOLD, onset);
    write_register(REG_CALIBRATION_LENGTH, cal_len);
    write_register(REG_MIN_WORD_LENGTH, min_word);
    write_register(REG_MIN_DISCARD_LENGTH, min_discard);
    write_register(REG_SILENCE_LIMIT, silence);
  endtask

  function automatic logic signed [15:0] tone(input int mag, input bit negative);
    return negative ? 16'(-mag) : 16'(mag);
  endfunction

  // Now and then a sample is replaced by any 16-bit value, and very rarely a
  // recording is cut by a restart, so that broken sequences are mixed in.
  task automatic send_rough_beat(input logic signed [15:0] s);
    logic signed [15:0] v;
    v = ($urandom_range(0, 29) == 0) ? 16'($urandom) : s;
    send_beat(v, $urandom_range(0, 499) == 0);
  endtask

  // One recording: a restart, the calibration noise, then words, each a loud
  // oscillating burst followed by enough quiet zero-crossing cycles to end it.
  task automatic send_recording(input int n_words, input int noise_amp);
    int cal_len;
    int loud_lo;
    int burst;
    int burst_max;
    int half;
    int cycles;
    int mag;
    bit neg;
    cal_len = int'(seg_cfg.calibration_length);
    send_beat(16'(int'($urandom_range(0, 2 * noise_amp)) - noise_amp), 1'b1);
    // Positions 1 to the calibration length; the last one is the skipped sample.
    for (int i = 1; i <= cal_len; i++)
      send_rough_beat(16'(int'($urandom_range(0, 2 * noise_amp)) - noise_amp));

    loud_lo = int'(seg_cfg.onset_threshold);
    if (noise_amp > loud_lo) loud_lo = noise_amp;
    if (QUIET_MAG > loud_lo) loud_lo = QUIET_MAG;
    loud_lo = (loud_lo >= MAG_LIMIT) ? MAG_LIMIT : loud_lo + 1;
    burst_max = (seg_cfg.min_word_length > 60) ? 80 : int'(seg_cfg.min_word_length) + 20;

    for (int w = 0; w < n_words; w++) begin
      // Burst lengths straddle a minimum word length of up to 60, so some words are dropped.
      burst = $urandom_range(1, burst_max);
      half = $urandom_range(1, 4);
      for (int j = 0; j < burst; j++) begin
        neg = ((j / half) % 2) == 1;
        mag = neg ? $urandom_range(loud_lo, MAG_LIMIT + 1) : $urandom_range(loud_lo, MAG_LIMIT);
        send_rough_beat(tone(mag, neg));
      end
      cycles = int'(seg_cfg.silence_limit) + 2 + $urandom_range(0, 2);
      half = (seg_cfg.silence_limit > 8) ? 1 : $urandom_range(1, 3);
      for (int c = 0; c < cycles; c++) begin
        for (int k = 0; k < half; k++) send_rough_beat(tone($urandom_range(0, QUIET_MAG), 1'b0));
        for (int k = 0; k < half; k++) send_rough_beat(tone($urandom_range(1, QUIET_MAG), 1'b1));
      end
    end
  endtask

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Defaults after reset, both extremes of every register, and an ignored address.
  task automatic test_register_access();
    for (int i = REG_ONSET_THRESHOLD; i <= REG_SILENCE_LIMIT; i++) verify_register(i);
    for (int i = REG_ONSET_THRESHOLD; i <= REG_SILENCE_LIMIT; i++) begin
      write_register(i, '0);
      verify_register(i);
      // All ones: each register keeps only its own width.
      write_register(i, '1);
      verify_register(i);
    end
    write_register(SPARE_REG_IDX, 32'h0000_1234);
    for (int i = REG_ONSET_THRESHOLD; i <= REG_SILENCE_LIMIT; i++) verify_register(i);
  endtask

  // A hand-built stream: clipped magnitudes, the skipped sample, a word that is
  // reported after one quiet cycle, a short burst that is dropped, and a restart.
  task automatic test_directed_word();
    int pattern [21] = '{5, -3, 32767, -32768, -200, 300, -5, 0, -4, 3, -2, 1,
                         -500, 2, -1, 1, -1, 0, -1, -32768, 32767};
    write_settings(100, 2, 8, 2, 1);
    idling_on = 1'b1;
    // The first beat and the one after the dropped burst start new recordings.
    for (int i = 0; i < 21; i++) send_beat(16'(pattern[i]), i == 0 || i == 18);
    pause_until_drained();
  endtask

  // The longest calibration span, where nothing can open a word, then none at all.
  task automatic test_calibration_extremes();
    write_settings(300, 24'hFF_FFFF, 20, 5, 2);
    send_beat(16'sh8000, 1'b1);
    send_beat(16'sh7FFF, 1'b0);
    repeat (14) send_beat(16'($urandom), 1'b0);
    write_settings(300, 0, 20, 5, 2);
    send_recording(3, 20);
    pause_until_drained();
  endtask

  // The largest silence limit: the quiet counter tops out and one more cycle ends it.
  task automatic test_silence_ceiling();
    write_settings(200, 4, 10, 3, 8'hFF);
    idling_on = $urandom_range(0, 1);
    send_recording(1, 10);
    pause_until_drained();
  endtask

  // Random settings, each followed by a few recordings with random content; runs
  // on until enough samples went in.
  task automatic test_random_recordings();
    int onset;
    int cal_len;
    int min_word;
    int min_discard;
    int silence;
    while (beats_sent < 1050) begin
      onset       = $urandom_range(20, 3000);
      cal_len     = $urandom_range(1, 30);
      min_word    = $urandom_range(0, 40);
      min_discard = $urandom_range(0, 20);
      silence     = $urandom_range(0, 5);
      case ($urandom_range(0, 9))
        0: begin
          onset = 0;
          cal_len = 1;
          min_word = 0;
          min_discard = 0;
          silence = 0;
        end
        1: onset = MAG_LIMIT;
        2: begin
          min_word = 16'hFFFF;
          min_discard = 16'hFFFF;
        end
        3: min_word = 16'hFFFF;
        default: ;
      endcase
      write_settings(onset, cal_len, min_word, min_discard, silence);
      repeat ($urandom_range(1, 3)) begin
        // Roughly one recording in four runs with no idling on either side.
        idling_on = $urandom_range(0, 3) != 0;
        send_recording($urandom_range(1, 16),
                       ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3000)
                                                   : $urandom_range(0, 40));
        if ($urandom_range(0, 7) == 0) pause_until_drained();
      end
    end
  endtask

  // Back-to-back samples with ready held high for the closing stretch.
  task automatic test_steady_stream();
    write_settings(150, 8, 24, 6, 2);
    idling_on = 1'b0;
    send_recording(3, 15);
    pause_until_drained();
  endtask

  initial begin
    in_ch.valid   <= 1'b0;
    in_ch.sample  <= '0;
    in_ch.restart <= 1'b0;
    reset_shadow();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_access();
    test_directed_word();
    test_calibration_extremes();
    test_silence_ceiling();
    test_random_recordings();
    test_steady_stream();

    // Anything the block emits late or unasked is caught by the checker here.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sws_pkg.sv
rtl/sws_if.sv
rtl/sws_core.sv
rtl/spoken_word_segmenter.sv
dv/spoken_word_segmenter_test.sv
